// ===== src/assert_macros.svh =====
// Assertion macros for the RTL; clock clk, active-low reset rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define LCRT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define LCRT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define LCRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lcrt_pkg.sv =====
// Shared constants and types for the longest consecutive run tracker
`default_nettype none

package lcrt_pkg;

  // Default key width
  localparam int KEY_BITS_DEF = 16;

  // Set tag stored with each table word; a word is live only when its tag matches
  localparam int EPOCH_BITS = 4;

  // Control from the pipeline to the run table
  typedef struct packed {
    logic sweep_req;  // start a full clear pass
    logic hold;       // pipeline writes still pending, sweep must wait
  } tbl_ctl_t;

endpackage

`default_nettype wire

// ===== src/lcrt_table.sv =====
// Run-length table: one write port, two registered read ports, set tags, clear sweep
`default_nettype none

module lcrt_table import lcrt_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tbl_ctl_t              ctl,
  input  logic [EPOCH_BITS-1:0] epoch,
  input  logic [KEY_BITS-1:0]   rd_addr_a,
  input  logic [KEY_BITS-1:0]   rd_addr_b,
  output logic [KEY_BITS:0]     rd_len_a,
  output logic [KEY_BITS:0]     rd_len_b,
  input  logic                  wr_en,
  input  logic [KEY_BITS-1:0]   wr_addr,
  input  logic [KEY_BITS:0]     wr_len,
  input  logic [EPOCH_BITS-1:0] wr_tag,
  output logic                  busy
);

  localparam int LEN_BITS  = KEY_BITS + 1;
  localparam int WORD_BITS = LEN_BITS + EPOCH_BITS;
  localparam int DEPTH     = 1 << KEY_BITS;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_a_r, rd_b_r;

  logic                 sweep_r, sweep_nxt;
  logic [KEY_BITS-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic                 sweep_wr;

  logic                 mem_we;
  logic [KEY_BITS-1:0]  mem_addr;
  logic [WORD_BITS-1:0] mem_data;

  // Sweep owns the write port once pipeline writes have drained
  assign sweep_wr = sweep_r && !ctl.hold;
  assign mem_we   = sweep_wr || wr_en;
  assign mem_addr = sweep_wr ? sweep_addr_r : wr_addr;
  assign mem_data = sweep_wr ? '0 : {wr_tag, wr_len};

  // Storage, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  // Clear pass sequencing
  always_comb begin
    sweep_nxt      = sweep_r;
    sweep_addr_nxt = sweep_addr_r;
    if (sweep_wr) begin
      sweep_addr_nxt = sweep_addr_r + KEY_BITS'(1);
      if (sweep_addr_r == '1) begin
        sweep_nxt = 1'b0;
      end
    end
    if (ctl.sweep_req) begin
      sweep_nxt      = 1'b1;
      sweep_addr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r      <= 1'b1;
      sweep_addr_r <= '0;
    end else begin
      sweep_r      <= sweep_nxt;
      sweep_addr_r <= sweep_addr_nxt;
    end
  end

  // A word from another set reads as empty
  assign rd_len_a = (rd_a_r[WORD_BITS-1 -: EPOCH_BITS] == epoch) ? rd_a_r[LEN_BITS-1:0] : '0;
  assign rd_len_b = (rd_b_r[WORD_BITS-1 -: EPOCH_BITS] == epoch) ? rd_b_r[LEN_BITS-1:0] : '0;

  assign busy = sweep_r;

endmodule

`default_nettype wire

// ===== src/longest_consecutive_run_tracker.sv =====
// A result is offered once its item has passed s0, s1 and s2 into the result buffer.
// Issue: an item is taken once the last one leaves s0 and s1 and a result slot is free,
//   set by the single write port (key, run ends) overlapped with the next item's reads.
// Reset: control clears at once, then a clear pass sweeps all 2^KEY_BITS table words;
//   the same pass runs again after every 16th set end, with no input taken meanwhile.
`default_nettype none
`include "assert_macros.svh"

module longest_consecutive_run_tracker import lcrt_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KEY_BITS-1:0] in_key_value,
  input  logic                in_set_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KEY_BITS:0]   out_longest_run,
  output logic                out_was_duplicate,
  output logic                out_final_answer
);

  localparam int LEN_BITS = KEY_BITS + 1;

  // Pipeline: s0 read key and key-1, s1 read key+1, s2 compute and write key,
  // s3 write low run end, s4 write high run end
  logic                v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [KEY_BITS-1:0] k0_r, k1_r, k2_r;
  logic                last0_r, last1_r, last2_r;
  logic                self_hit_r;
  logic [LEN_BITS-1:0] left_r;

  // Last item through s2: write-back targets, also used for forwarding
  logic                  p_fwd_r;
  logic [KEY_BITS-1:0]   p_key_r, p_lo_r, p_hi_r;
  logic                  p_lo_en_r, p_hi_en_r;
  logic [LEN_BITS-1:0]   p_len_r;
  logic [EPOCH_BITS-1:0] p_tag_r;

  logic [LEN_BITS-1:0]   best_r, best_nxt;
  logic [EPOCH_BITS-1:0] epoch_r, epoch_nxt;

  // Result buffer, two entries
  logic [LEN_BITS-1:0] ob_len_r [2];
  logic                ob_dup_r [2];
  logic                ob_fin_r [2];
  logic                ob_wp_r, ob_rp_r;
  logic [1:0]          ob_cnt_r;
  logic                push, pop;

  // Table interface
  tbl_ctl_t              tbl_ctl;
  logic [KEY_BITS-1:0]   rd_addr_a, rd_addr_b;
  logic [LEN_BITS-1:0]   rd_len_a, rd_len_b;
  logic                  wr_en;
  logic [KEY_BITS-1:0]   wr_addr;
  logic [LEN_BITS-1:0]   wr_len;
  logic [EPOCH_BITS-1:0] wr_tag;
  logic                  tbl_busy;

  logic                accept;
  logic [KEY_BITS-1:0] k1_dn, k1_up, k2_up;
  logic                hit_self, hit_left, hit_right;
  logic [LEN_BITS-1:0] self_len, left_len, right_len;
  logic [LEN_BITS-1:0] left_c, right_c, len_s2, best_upd;
  logic [KEY_BITS-1:0] lo_s2, hi_s2;
  logic                dup_s2, wrap_s2;

  lcrt_table #(
    .KEY_BITS (KEY_BITS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tbl_ctl),
    .epoch     (epoch_r),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_len_a  (rd_len_a),
    .rd_len_b  (rd_len_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_len    (wr_len),
    .wr_tag    (wr_tag),
    .busy      (tbl_busy)
  );

  // Input handshake: front stages empty, no clear pass, result slot reserved
  assign wrap_s2  = v2_r && last2_r && (epoch_r == '1);
  assign in_ready = !v0_r && !v1_r && !tbl_busy && !wrap_s2 &&
                    ((ob_cnt_r == 2'd0) || ((ob_cnt_r == 2'd1) && !v2_r));
  assign accept   = in_valid && in_ready;

  // Read addresses
  assign k1_dn     = k1_r - KEY_BITS'(1);
  assign k1_up     = k1_r + KEY_BITS'(1);
  assign k2_up     = k2_r + KEY_BITS'(1);
  assign rd_addr_a = v1_r ? k1_up : k0_r;
  assign rd_addr_b = k0_r - KEY_BITS'(1);

  // Forward the previous item's value over writes the reads could have missed
  always_comb begin
    hit_self  = p_fwd_r && ((k1_r == p_key_r) || (p_lo_en_r && (k1_r == p_lo_r)) ||
                            (p_hi_en_r && (k1_r == p_hi_r)));
    hit_left  = p_fwd_r && ((k1_dn == p_key_r) || (p_lo_en_r && (k1_dn == p_lo_r)) ||
                            (p_hi_en_r && (k1_dn == p_hi_r)));
    hit_right = p_fwd_r && ((k2_up == p_key_r) || (p_lo_en_r && (k2_up == p_lo_r)) ||
                            (p_hi_en_r && (k2_up == p_hi_r)));
    self_len  = hit_self  ? p_len_r : rd_len_a;
    left_len  = hit_left  ? p_len_r : rd_len_b;
    right_len = hit_right ? p_len_r : rd_len_a;
    if (k2_r == '1) begin
      right_len = '0;
    end
  end

  // s2: merge neighbor runs, clamp to the domain
  always_comb begin
    left_c  = (left_r > {1'b0, k2_r}) ? {1'b0, k2_r} : left_r;
    right_c = (right_len > {1'b0, ~k2_r}) ? {1'b0, ~k2_r} : right_len;
    len_s2  = left_c + right_c + LEN_BITS'(1);
    lo_s2   = k2_r - left_c[KEY_BITS-1:0];
    hi_s2   = k2_r + right_c[KEY_BITS-1:0];
    dup_s2  = self_hit_r;
    if (dup_s2 || (len_s2 <= best_r)) begin
      best_upd = best_r;
    end else begin
      best_upd = len_s2;
    end
  end

  // Longest run and set tag
  always_comb begin
    best_nxt  = best_r;
    epoch_nxt = epoch_r;
    if (v2_r) begin
      best_nxt = last2_r ? '0 : best_upd;
      if (last2_r) begin
        epoch_nxt = epoch_r + EPOCH_BITS'(1);
      end
    end
  end

  // Write port: stages s2, s3 and s4 never hold items at once
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = k2_r;
    wr_len  = len_s2;
    wr_tag  = epoch_r;
    if (v2_r && !dup_s2) begin
      wr_en = 1'b1;
    end else if (v3_r && p_lo_en_r) begin
      wr_en   = 1'b1;
      wr_addr = p_lo_r;
      wr_len  = p_len_r;
      wr_tag  = p_tag_r;
    end else if (v4_r && p_hi_en_r) begin
      wr_en   = 1'b1;
      wr_addr = p_hi_r;
      wr_len  = p_len_r;
      wr_tag  = p_tag_r;
    end
  end

  assign tbl_ctl.sweep_req = wrap_s2;
  assign tbl_ctl.hold      = v3_r || v4_r;

  // Stage valids and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      p_fwd_r <= 1'b0;
      best_r  <= '0;
      epoch_r <= '0;
    end else begin
      v0_r    <= accept;
      v1_r    <= v0_r;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      best_r  <= best_nxt;
      epoch_r <= epoch_nxt;
      if (v2_r) begin
        p_fwd_r <= !dup_s2 && !last2_r;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      k0_r    <= in_key_value;
      last0_r <= in_set_end;
    end
    k1_r       <= k0_r;
    last1_r    <= last0_r;
    k2_r       <= k1_r;
    last2_r    <= last1_r;
    self_hit_r <= (self_len != '0);
    left_r     <= (k1_r == '0) ? '0 : left_len;
    if (v2_r) begin
      p_key_r   <= k2_r;
      p_lo_r    <= lo_s2;
      p_hi_r    <= hi_s2;
      p_lo_en_r <= !dup_s2 && (left_c != '0);
      p_hi_en_r <= !dup_s2 && (right_c != '0);
      p_len_r   <= len_s2;
      p_tag_r   <= epoch_r;
    end
  end

  // Result buffer
  assign push = v2_r;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wp_r  <= 1'b0;
      ob_rp_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      if (push) begin
        ob_wp_r <= !ob_wp_r;
      end
      if (pop) begin
        ob_rp_r <= !ob_rp_r;
      end
      ob_cnt_r <= ob_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ob_len_r[ob_wp_r] <= best_upd;
      ob_dup_r[ob_wp_r] <= dup_s2;
      ob_fin_r[ob_wp_r] <= last2_r;
    end
  end

  assign out_valid         = (ob_cnt_r != 2'd0);
  assign out_longest_run   = ob_len_r[ob_rp_r];
  assign out_was_duplicate = ob_dup_r[ob_rp_r];
  assign out_final_answer  = ob_fin_r[ob_rp_r];

  // Checks
  `LCRT_ASSERT_ALWAYS(a_front_single, $onehot0({v0_r, v1_r, v2_r}), "two items in front stages")
  `LCRT_ASSERT_IMPLY(a_buf_room, push, (ob_cnt_r != 2'd2) || pop, "result buffer overflow")
  `LCRT_ASSERT_IMPLY(a_sweep_quiet, tbl_busy, !in_ready && !v2_r, "item active during clear pass")
  `LCRT_ASSERT_NEXT(a_epoch_step, v2_r && last2_r,
                    epoch_r == EPOCH_BITS'($past(epoch_r) + 1'b1), "set tag not advanced")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for longest_consecutive_run_tracker: random and directed key sets, scoreboard check
`timescale 1ns / 100ps

module tb import lcrt_pkg::*; ();

  localparam int KEY_BITS = KEY_BITS_DEF;
  localparam int LEN_BITS = KEY_BITS + 1;
  localparam int KEY_MAX = (1 << KEY_BITS) - 1;
  localparam int RANDOM_ITEMS = 480;
  // a clear pass of the whole table holds off input while it sweeps all 2^KEY_BITS words
  localparam int QUIET_LIMIT = 4 * (1 << KEY_BITS) + 1000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [KEY_BITS-1:0] key;
    logic                last;
  } key_item_t;

  typedef struct {
    logic [LEN_BITS-1:0] longest;
    logic                was_dup;
    logic                final_answer;
  } run_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KEY_BITS-1:0] in_key_value = '0;
  logic                in_set_end = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LEN_BITS-1:0] out_longest_run;
  logic                out_was_duplicate;
  logic                out_final_answer;

  longest_consecutive_run_tracker #(.KEY_BITS(KEY_BITS)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_key_value      (in_key_value),
    .in_set_end        (in_set_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_longest_run   (out_longest_run),
    .out_was_duplicate (out_was_duplicate),
    .out_final_answer  (out_final_answer)
  );

  // Predictor state: sparse copy of the run-length table and the best run so far
  logic [LEN_BITS-1:0] run_len [int];
  int                  best_len = 0;

  key_item_t   keys_to_send [$];
  run_result_t run_results_due [$];
  run_result_t want;
  key_item_t   next_key;

  int total_items = 0;
  int idle_phase = 0;
  int send_idle_pct [3] = '{8, 57, 0};
  int recv_idle_pct [3] = '{57, 8, 0};
  int quiet_cycles = 0;
  int err_cnt = 0;
  int results_checked = 0;
  int dups_seen = 0;
  int sets_closed = 0;
  int peak_run = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic int len_at(input int addr);
    return run_len.exists(addr) ? int'(run_len[addr]) : 0;
  endfunction

  // Insert one key into the run table and return the expected result
  function automatic run_result_t track_key(input logic [KEY_BITS-1:0] key, input logic last);
    run_result_t r;
    int k, lt, rt, ln;
    k = int'(key);
    lt = 0;
    rt = 0;
    r.was_dup = (len_at(k) != 0);
    if (!r.was_dup) begin
      // neighbors beyond either edge of the key domain count as absent
      if (k > 0) lt = len_at(k - 1);
      if (k < KEY_MAX) rt = len_at(k + 1);
      if (lt > k) lt = k;
      if (k + rt > KEY_MAX) rt = KEY_MAX - k;
      ln = 1 + lt + rt;
      run_len[k] = LEN_BITS'(ln);
      if (lt != 0) run_len[k - lt] = LEN_BITS'(ln);
      if (rt != 0) run_len[k + rt] = LEN_BITS'(ln);
      if (ln > best_len) best_len = ln;
    end
    r.longest = LEN_BITS'(best_len);
    r.final_answer = last;
    // set end: result first, then everything clears
    if (last) begin
      run_len.delete();
      best_len = 0;
    end
    return r;
  endfunction

  task automatic add_key(input int key, input logic last);
    key_item_t it;
    it.key = KEY_BITS'(key);
    it.last = last;
    keys_to_send.push_back(it);
  endtask

  // Driver: load the next pending transaction once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (keys_to_send.size() > (2 * total_items) / 3)
        idle_phase <= 0;
      else if (keys_to_send.size() > total_items / 3)
        idle_phase <= 1;
      else
        idle_phase <= 2;
      if (!in_valid || in_ready) begin
        if (keys_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct[idle_phase]) begin
          next_key = keys_to_send.pop_front();
          in_valid <= 1'b1;
          in_key_value <= next_key.key;
          in_set_end <= next_key.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_idle_pct[idle_phase]);
  end

  // Monitor: check results against the oldest expectation, then predict new inputs
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (run_results_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: longest=%0d dup=%0b final=%0b",
                                    out_longest_run, out_was_duplicate, out_final_answer));
        end else begin
          want = run_results_due.pop_front();
          results_checked++;
          if (out_longest_run !== want.longest)
            report_mismatch($sformatf("result %0d longest_run got %0d want %0d",
                                      results_checked, out_longest_run, want.longest));
          if (out_was_duplicate !== want.was_dup)
            report_mismatch($sformatf("result %0d was_duplicate got %b want %b",
                                      results_checked, out_was_duplicate, want.was_dup));
          if (out_final_answer !== want.final_answer)
            report_mismatch($sformatf("result %0d final_answer got %b want %b",
                                      results_checked, out_final_answer, want.final_answer));
          if (want.was_dup) dups_seen++;
          if (want.final_answer) sets_closed++;
          if (int'(want.longest) > peak_run) peak_run = int'(want.longest);
        end
      end
      if (in_valid && in_ready)
        run_results_due.push_back(track_key(in_key_value, in_set_end));
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int set_len, span, pick, base, prev_base;
    bit noisy, timed_out;
    prev_base = 0;
    timed_out = 1'b0;

    // Directed: domain edges, no wrap between 0 and max, merges, duplicates
    add_key(0, 1'b0);
    add_key(1, 1'b0);
    add_key(KEY_MAX, 1'b0);
    add_key(KEY_MAX - 1, 1'b0);
    add_key(KEY_MAX, 1'b0);
    add_key(3, 1'b0);
    add_key(2, 1'b0);
    add_key(0, 1'b1);            // duplicate closes the set
    add_key(KEY_MAX, 1'b0);      // table must be clear again
    add_key(0, 1'b0);
    add_key(16'hAAAA, 1'b0);
    add_key(16'h5555, 1'b0);
    add_key(100, 1'b0);
    add_key(102, 1'b0);
    add_key(104, 1'b0);
    add_key(101, 1'b0);          // joins runs on both sides
    add_key(103, 1'b1);
    add_key(7, 1'b1);            // single-item set

    // Random sets: mostly clustered keys to build and merge runs, some noise
    while (keys_to_send.size() < 18 + RANDOM_ITEMS) begin
      set_len = $urandom_range(1, 30);
      noisy = ($urandom_range(99) < 15);
      span = $urandom_range(2, 40);
      pick = $urandom_range(9);
      if (pick == 0)
        base = 0;
      else if (pick == 1)
        base = KEY_MAX - span;
      else if (pick == 2 && prev_base <= KEY_MAX - span)
        base = prev_base;        // reuse keys of an earlier set
      else
        base = $urandom_range(KEY_MAX - span);
      prev_base = base;
      for (int j = 0; j < set_len; j++)
        add_key(noisy ? $urandom_range(KEY_MAX) : base + $urandom_range(span), j == set_len - 1);
    end
    total_items = keys_to_send.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all transactions to be taken and answered, or for the watchdog
    @(negedge clk);
    while (!timed_out && (keys_to_send.size() != 0 || in_valid || run_results_due.size() != 0)) begin
      @(negedge clk);
      if (quiet_cycles >= QUIET_LIMIT) timed_out = 1'b1;
    end

    if (timed_out) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, run_results_due.size());
      $display("Test completed with failures");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      $display("Checked %0d results over %0d key sets (%0d items sent)",
               results_checked, sets_closed, total_items);
      $display("Duplicates skipped: %0d, longest run reached: %0d, mismatches: %0d",
               dups_seen, peak_run, err_cnt);
      if (err_cnt == 0)
        $display("Test completed successfully");
      else
        $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/lcrt_pkg.sv
src/lcrt_table.sv
src/longest_consecutive_run_tracker.sv
verif/tb.sv
